>>> src/tlrcs_pkg.sv
package tlrcs_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_ROW_WR = 2'b00,
        CMD_COL_WR = 2'b01,
        CMD_PIX_WR = 2'b10,
        CMD_RENDER = 2'b11
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_SCROLL_X      = 3'd0,
        REG_SCROLL_Y      = 3'd1,
        REG_LINE_DELTA    = 3'd2,
        REG_FLIP_SCREEN   = 3'd3,
        REG_IGNORE_TRANSP = 3'd4,
        REG_PRIO_ENABLE   = 3'd5,
        REG_PRIO_CODE     = 3'd6
    } t_reg_idx;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ENTRY_W = 16;
    localparam int COL_AW = 7;
    localparam int COL_SHIFT = 3;
    localparam int FLIP_Y_BASE = 256;
    localparam int FLIP_X_BASE = 192;
    localparam logic [ENTRY_W-1:0] PIXEL_INDEX_MASK = 16'h000f;

    typedef struct packed {
        t_cmd        cmd;
        logic [17:0] address;
        logic [15:0] data;
        logic [9:0]  screen_x;
        logic [8:0]  screen_y;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel;
        logic        pixel_write;
        logic        priority_write;
        logic [7:0]  priority_value;
        logic [9:0]  dest_x;
        logic [8:0]  dest_y;
    } t_out_item;

    typedef struct packed {
        logic [15:0] scroll_x;
        logic [15:0] scroll_y;
        logic [10:0] line_delta;
        logic        flip_screen;
        logic        ignore_transparency;
        logic        priority_enable;
        logic [7:0]  priority_code;
    } t_cfg;

endpackage

>>> src/tlrcs_cfg.sv
module tlrcs_cfg
    import tlrcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Keep the low register-width bits; ignore indexes past the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCROLL_X:      r_cfg.scroll_x <= i_cfg_data;
                REG_SCROLL_Y:      r_cfg.scroll_y <= i_cfg_data;
                REG_LINE_DELTA:    r_cfg.line_delta <= i_cfg_data[10:0];
                REG_FLIP_SCREEN:   r_cfg.flip_screen <= i_cfg_data[0];
                REG_IGNORE_TRANSP: r_cfg.ignore_transparency <= i_cfg_data[0];
                REG_PRIO_ENABLE:   r_cfg.priority_enable <= i_cfg_data[0];
                REG_PRIO_CODE:     r_cfg.priority_code <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/tlrcs_row_mem.sv
module tlrcs_row_mem
    import tlrcs_pkg::*;
#(
    parameter int AW = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_we,
    input  logic [AW-1:0]      i_addr,
    input  logic [ENTRY_W-1:0] i_wdata,
    output logic [ENTRY_W-1:0] o_rdata,
    output logic               o_busy
);

    logic [ENTRY_W-1:0] r_mem [2**AW];
    logic [ENTRY_W-1:0] r_rdata;
    logic [AW-1:0]      r_clr_idx;
    logic               r_busy;

    // Sweep the table to zero after reset, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {AW{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Single port: clear, write, or registered read
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

>>> src/tlrcs_col_mem.sv
module tlrcs_col_mem
    import tlrcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_we,
    input  logic [COL_AW-1:0]  i_addr,
    input  logic [ENTRY_W-1:0] i_wdata,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [2**COL_AW];
    logic [2**COL_AW-1:0] r_vld;
    logic [ENTRY_W-1:0] r_rdata;
    logic               r_rvld;

    // Entry storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    // Mark written entries; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else if (i_en) begin
            if (i_we) begin
                r_vld[i_addr] <= 1'b1;
            end else begin
                r_rvld <= r_vld[i_addr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

>>> src/tile_layer_row_column_scroll_render_top.sv
// Scrolling tile layer renderer. Each input beat is either a table or pixmap write or a
// render of one screen pixel; a render returns one result beat, writes return nothing.
// The pipeline takes one beat every cycle and stalls only under output back-pressure
// or while the row-scroll table is cleared: stage one reads the row-scroll table, stage
// two the column-scroll table, stage three the pixmap, and the output register holds
// the result. Writes commit at the same stage that reads their table, so every beat
// sees all earlier writes. After reset the row-scroll table is zeroed, during which
// o_in_ready stays low. The configuration port is always ready; write it only while
// no render is in flight. Pixmap words must be written before they are rendered.
module tile_layer_row_column_scroll_render_top
    import tlrcs_pkg::*;
#(
    parameter int PIXMAP_WIDTH_BITS  = 9,
    parameter int PIXMAP_HEIGHT_BITS = 9,
    parameter int ROW_TABLE_DEPTH    = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW     = PIXMAP_WIDTH_BITS;
    localparam int PH     = PIXMAP_HEIGHT_BITS;
    localparam int PIX_AW = PW + PH;
    localparam int ROW_AW = $clog2(ROW_TABLE_DEPTH);

    t_cfg w_cfg;

    logic w_busy;
    logic w_acc, w_adv2, w_adv3;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic               r_v1, r_v2, r_v3, r_out_valid;
    t_in_item           r1_item, r2_item, r3_item;
    logic [PH-1:0]      r1_ys, r2_ys;
    logic [PW-1:0]      r2_col;
    logic [ENTRY_W-1:0] r3_pix;
    t_out_item          r_out_item;

    logic [PH-1:0]      w_ys_base, w_ys;
    logic [ROW_AW-1:0]  w_row_addr;
    logic [ENTRY_W-1:0] w_row_data;
    logic [PW-1:0]      w_xs, w_xs_f, w_col;
    logic [COL_AW-1:0]  w_col_addr;
    logic [ENTRY_W-1:0] w_col_data;
    logic [PH-1:0]      w_row;
    logic               w_opaque, w_prio;

    logic [ENTRY_W-1:0] r_pixmap [2**PIX_AW];

    tlrcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // Stall chain: a stage loads when empty or when its downstream moves
    assign w_rdy4     = !r_out_valid || i_out_ready;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1 && !w_busy;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_adv2     = r_v1 && w_rdy2;
    assign w_adv3     = r_v2 && w_rdy3;

    // Stage 1 entry: source row base and row-scroll lookup
    assign w_ys_base  = w_cfg.flip_screen ? (PH'(FLIP_Y_BASE) - w_cfg.scroll_y[PH-1:0])
                                          : w_cfg.scroll_y[PH-1:0];
    assign w_ys       = w_ys_base + PH'(i_in_item.screen_y);
    assign w_row_addr = (i_in_item.cmd == CMD_ROW_WR) ? ROW_AW'(i_in_item.address)
                      : ROW_AW'(i_in_item.screen_y) + ROW_AW'(w_cfg.line_delta);

    tlrcs_row_mem #(
        .AW (ROW_AW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_acc),
        .i_we    (i_in_item.cmd == CMD_ROW_WR),
        .i_addr  (w_row_addr),
        .i_wdata (i_in_item.data),
        .o_rdata (w_row_data),
        .o_busy  (w_busy)
    );

    // Stage 2 entry: source column and column-scroll lookup
    assign w_xs       = PW'(w_cfg.scroll_x) - PW'(w_row_data);
    assign w_xs_f     = w_cfg.flip_screen ? (PW'(FLIP_X_BASE) - w_xs) : w_xs;
    assign w_col      = w_xs_f + PW'(r1_item.screen_x);
    assign w_col_addr = (r1_item.cmd == CMD_COL_WR) ? COL_AW'(r1_item.address)
                      : COL_AW'(w_col >> COL_SHIFT);

    tlrcs_col_mem u_col_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv2),
        .i_we    (r1_item.cmd == CMD_COL_WR),
        .i_addr  (w_col_addr),
        .i_wdata (r1_item.data),
        .o_rdata (w_col_data)
    );

    // Stage 3 entry: shifted source row and pixmap access
    assign w_row = r2_ys - PH'(w_col_data);

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            if (r2_item.cmd == CMD_PIX_WR) begin
                r_pixmap[PIX_AW'(r2_item.address)] <= r2_item.data;
            end else begin
                r3_pix <= r_pixmap[{w_row, r2_col}];
            end
        end
    end

    // Output entry: opacity and priority
    assign w_opaque = ((r3_pix & PIXEL_INDEX_MASK) != '0) || w_cfg.ignore_transparency;
    assign w_prio   = w_opaque && w_cfg.priority_enable;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= w_acc;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_out_valid <= r_v3 && (r3_item.cmd == CMD_RENDER);
            end
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_item <= i_in_item;
            r1_ys   <= w_ys;
        end
        if (w_adv2) begin
            r2_item <= r1_item;
            r2_ys   <= r1_ys;
            r2_col  <= w_col;
        end
        if (w_adv3) begin
            r3_item <= r2_item;
        end
        if (r_v3 && w_rdy4) begin
            r_out_item.pixel          <= r3_pix;
            r_out_item.pixel_write    <= w_opaque;
            r_out_item.priority_write <= w_prio;
            r_out_item.priority_value <= w_prio ? w_cfg.priority_code : '0;
            r_out_item.dest_x         <= r3_item.screen_x;
            r_out_item.dest_y         <= r3_item.screen_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_prio_needs_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.priority_write |-> o_out_item.pixel_write)
        else $error("priority write without pixel write");

    a_prio_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.priority_write |-> o_out_item.priority_value == '0)
        else $error("priority value set without priority write");

    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_rdy3 |=> $stable(r3_pix) && $stable(r3_item))
        else $error("stalled pixmap stage changed");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_rdy3 |=> r_v2 && $stable(r2_item) && $stable(r2_col))
        else $error("stalled column stage changed");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |=> !r_v1 || $past(r_v1))
        else $error("beat accepted during row table clear");
`endif

endmodule
